// ===== rtl/core/ssrp_pkg.sv =====
// ssrp_pkg: shared types, constants and helper functions of the ramp profile block
// used by every module in rtl/core; depends on nothing

package ssrp_pkg;

    // quarter-wave table size, and address width for its entries plus the end point
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] SINE_LAST = IDX_W'(SINE_TABLE_ENTRIES);

    // fixed-point constants for the table build
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // how a beat's position is produced
    localparam logic [1:0] KIND_FIXED = 2'd0;
    localparam logic [1:0] KIND_LINEAR = 2'd1;
    localparam logic [1:0] KIND_SMOOTH = 2'd2;

    // table of sin/pi, Q0.32, one entry per quarter-wave step
    typedef logic [30:0] t_k_rom [0:SINE_TABLE_ENTRIES];

    typedef struct packed {
        logic [31:0] start_pos;
        logic [31:0] speedup_pos;
        logic [31:0] end_pos;
        logic [31:0] speed;
        logic [31:0] accel_time;
        logic [31:0] const_time;
        logic [31:0] phase_step;
        logic [1:0]  ramp_mode;
    } t_cfg;

    // work item carried down the pipeline
    typedef struct packed {
        logic [1:0]  kind;
        logic        active;
        logic [31:0] fixed_pos;
        logic [32:0] tt;
        logic [31:0] dlt;
        logic [31:0] phase;
        logic [1:0]  quarter;
        logic [46:0] sterm;
    } t_work;

    // saturate a 35-bit signed sum to the 32-bit signed range
    function automatic logic [31:0] sat_q16(input logic [34:0] v);
        logic ovf;
        ovf = (v[34:31] != 4'b0000) && (v[34:31] != 4'b1111);
        if (!ovf) begin
            return v[31:0];
        end else if (v[34]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    // sine by a Horner series, then scaled by 1/pi
    function automatic t_k_rom build_k_rom();
        t_k_rom rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] k;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
            x2 = (x * x) >> 30;
            r = ONE_Q30;
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd210);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd156);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd110);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd72);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd42);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd20);
            r = ONE_Q30 - (((x2 * r) >> 30) / 64'd6);
            s = (x * r) >> 30;
            if (s > ONE_Q30) begin
                s = ONE_Q30;
            end
            k = (s * INV_PI_Q32) >> 30;
            rom[i] = k[30:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/ssrp_if.sv =====
// ssrp_if: valid/ready channel interfaces for time beats in and position beats out
// standalone; no package needed

interface ssrp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_time;

    modport source(output valid, output elapsed_time, input ready);
    modport sink(input valid, input elapsed_time, output ready);
endinterface

interface ssrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic               active;

    modport source(output valid, output position, output active, input ready);
    modport sink(input valid, input position, input active, output ready);
endinterface

// ===== rtl/core/sine_smoothed_ramp_profile_top.sv =====
// sine_smoothed_ramp_profile_top: top level of the cycloidal ramp profile generator
// depends on ssrp_pkg, ssrp_if, ssrp_cfg_regs, ssrp_classify, ssrp_sine, ssrp_scale
//
// channel  | direction | handshake       | beat payload
// ---------+-----------+-----------------+------------------------------------------
// i_in     | in        | valid/ready     | elapsed_time[31:0], ticks
// o_out    | out       | valid/ready     | position[31:0] Q16.16 signed, active
// apb      | in        | psel/penable    | 8 registers at byte address 4*index
//
// one beat per cycle sustained while the output is not held; stages: 2 classify, 3 sine table, 6 scale
// each stage carries its own valid bit, so bubbles close up while the output is held
// a stalled output beat holds in the output register; nothing is dropped or repeated
// reset clears the valid bits and the configuration registers to zero; the sin/pi table
// is a constant rom, so no clearing pass is needed after reset

module sine_smoothed_ramp_profile_top import ssrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssrp_in_if.sink     i_in,
    ssrp_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    logic cls_valid;
    logic cls_ready;
    t_work cls_data;
    logic sin_valid;
    logic sin_ready;
    t_work sin_data;
    logic [31:0] out_pos;

    // configuration registers
    ssrp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // segment select and phase
    ssrp_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_time  (i_in.elapsed_time),
        .o_valid (cls_valid),
        .i_ready (cls_ready),
        .o_data  (cls_data)
    );

    // sine table lookup
    ssrp_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_data  (cls_data),
        .o_valid (sin_valid),
        .i_ready (sin_ready),
        .o_data  (sin_data)
    );

    // speed product, base add and saturation
    ssrp_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (sin_valid),
        .o_ready    (sin_ready),
        .i_data     (sin_data),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_position (out_pos),
        .o_active   (o_out.active)
    );

    assign o_out.position = $signed(out_pos);

endmodule

// ===== rtl/core/ssrp_cfg_regs.sv =====
// ssrp_cfg_regs: APB-style register bank holding the profile settings
// depends on ssrp_pkg (t_cfg)

module ssrp_cfg_regs import ssrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_SPEEDUP = 3'd1;
    localparam logic [2:0] REG_END = 3'd2;
    localparam logic [2:0] REG_SPEED = 3'd3;
    localparam logic [2:0] REG_ACCEL = 3'd4;
    localparam logic [2:0] REG_CONST = 3'd5;
    localparam logic [2:0] REG_PHASE = 3'd6;
    localparam logic [2:0] REG_MODE = 3'd7;

    t_cfg r_cfg;
    logic wr_en;
    logic [2:0] reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START:   r_cfg.start_pos <= pwdata;
                REG_SPEEDUP: r_cfg.speedup_pos <= pwdata;
                REG_END:     r_cfg.end_pos <= pwdata;
                REG_SPEED:   r_cfg.speed <= pwdata;
                REG_ACCEL:   r_cfg.accel_time <= pwdata;
                REG_CONST:   r_cfg.const_time <= pwdata;
                REG_PHASE:   r_cfg.phase_step <= pwdata;
                REG_MODE:    r_cfg.ramp_mode <= pwdata[1:0];
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (reg_idx)
            REG_START:   prdata = r_cfg.start_pos;
            REG_SPEEDUP: prdata = r_cfg.speedup_pos;
            REG_END:     prdata = r_cfg.end_pos;
            REG_SPEED:   prdata = r_cfg.speed;
            REG_ACCEL:   prdata = r_cfg.accel_time;
            REG_CONST:   prdata = r_cfg.const_time;
            REG_PHASE:   prdata = r_cfg.phase_step;
            REG_MODE:    prdata = {30'd0, r_cfg.ramp_mode};
        endcase
    end

endmodule

// ===== rtl/core/ssrp_classify.sv =====
// ssrp_classify: two stages that fold time for backwards mode, pick the profile segment
// and form the sine phase; depends on ssrp_pkg

module ssrp_classify import ssrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_time,
    output logic        o_valid,
    input  logic        i_ready,
    output t_work       o_data
);

    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_BACK_ZERO = 2'd1;
    localparam logic [1:0] PRE_BACK_END = 2'd2;

    logic r_v1;
    logic r_v2;
    logic en1;
    logic en2;
    logic slow;
    logic back;
    logic [32:0] end_t;
    logic [32:0] t_ext;
    logic [1:0] r_pre;
    logic [1:0] n_pre;
    logic [32:0] r_tt;
    logic [32:0] n_tt;
    logic [32:0] accel_ext;
    logic [32:0] lin_end;
    logic [32:0] twice_accel;
    logic [34:0] stop_sum;
    t_work r_out;
    t_work n_out;

    assign slow = i_cfg.ramp_mode[0];
    assign back = i_cfg.ramp_mode[1];

    // stall chain
    assign en2 = !r_v2 || i_ready;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_data = r_out;

    // stage 1: end time and time mirrored for backwards mode
    assign t_ext = {1'b0, i_time};
    assign end_t = slow ? {i_cfg.accel_time, 1'b0}
                        : {1'b0, i_cfg.accel_time} + {1'b0, i_cfg.const_time};

    always_comb begin
        n_tt = back ? (end_t - t_ext) : t_ext;
        priority if (back && (i_time == 32'd0)) begin
            n_pre = PRE_BACK_ZERO;
        end else if (back && (t_ext >= end_t)) begin
            n_pre = PRE_BACK_END;
        end else begin
            n_pre = PRE_NONE;
        end
    end

    // stage 2: segment select, constant positions and sine phase
    assign accel_ext = {1'b0, i_cfg.accel_time};
    assign lin_end = accel_ext + {1'b0, i_cfg.const_time};
    assign twice_accel = {i_cfg.accel_time, 1'b0};
    assign stop_sum = {{2{i_cfg.speedup_pos[31]}}, i_cfg.speedup_pos, 1'b0}
                    - {{3{i_cfg.start_pos[31]}}, i_cfg.start_pos};

    always_comb begin
        n_out.tt = r_tt;
        n_out.dlt = r_tt[31:0] - i_cfg.accel_time;
        n_out.phase = i_cfg.phase_step * r_tt[31:0];
        n_out.quarter = n_out.phase[31:30];
        n_out.sterm = '0;
        n_out.kind = KIND_FIXED;
        n_out.active = 1'b1;
        n_out.fixed_pos = i_cfg.start_pos;
        priority if (r_pre == PRE_BACK_ZERO) begin
            n_out.fixed_pos = slow ? i_cfg.start_pos : i_cfg.end_pos;
        end else if (r_pre == PRE_BACK_END) begin
            n_out.active = 1'b0;
        end else if (!slow && (r_tt >= accel_ext)) begin
            if (r_tt >= lin_end) begin
                n_out.fixed_pos = i_cfg.end_pos;
                n_out.active = 1'b0;
            end else begin
                n_out.kind = KIND_LINEAR;
            end
        end else if (r_tt >= twice_accel) begin
            // hold the stop point after the full smooth phase
            n_out.fixed_pos = sat_q16(stop_sum);
            n_out.active = 1'b0;
        end else begin
            n_out.kind = KIND_SMOOTH;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pre <= n_pre;
            r_tt <= n_tt;
        end
        if (en2) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/core/ssrp_sine.sv =====
// ssrp_sine: three stages that map the phase to a table address, read the sin/pi table
// and scale it by the acceleration time; depends on ssrp_pkg

module ssrp_sine import ssrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_data
);

    localparam int PROD_W = 30 + IDX_W;
    localparam t_k_rom K_ROM = build_k_rom();

    logic r_v3;
    logic r_v4;
    logic r_v5;
    logic en3;
    logic en4;
    logic en5;
    logic [PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_clip;
    logic [IDX_W-1:0] n_addr;
    logic [IDX_W-1:0] r_addr;
    logic [30:0] r_k;
    logic [62:0] sterm_prod;
    t_work r_d3;
    t_work r_d4;
    t_work r_d5;
    t_work n_d5;

    // stall chain
    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v5;
    assign o_data = r_d5;

    // stage 3: rounded table index, mirrored in odd quarters
    always_comb begin
        idx_prod = PROD_W'(i_data.phase[29:0]) * PROD_W'(SINE_TABLE_ENTRIES)
                 + (PROD_W'(1) << 29);
        idx_raw = idx_prod[PROD_W-1:30];
        idx_clip = (idx_raw > SINE_LAST) ? SINE_LAST : idx_raw;
        n_addr = i_data.quarter[0] ? (SINE_LAST - idx_clip) : idx_clip;
    end

    // stage 5: sine term in Q16 ticks
    always_comb begin
        sterm_prod = 63'(i_cfg.accel_time) * 63'(r_k);
        n_d5 = r_d4;
        n_d5.sterm = sterm_prod[62:16];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // stage data, with the table read registered in stage 4
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_d3 <= i_data;
            r_addr <= n_addr;
        end
        if (en4) begin
            r_d4 <= r_d3;
            r_k <= K_ROM[r_addr];
        end
        if (en5) begin
            r_d5 <= n_d5;
        end
    end

endmodule

// ===== rtl/core/ssrp_scale.sv =====
// ssrp_scale: six stages that multiply speed by the scaled time, add the base position
// and saturate; the last stage is the output register; depends on ssrp_pkg

module ssrp_scale import ssrp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_work       i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_position,
    output logic        o_active
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0] en;

    t_work r_d6;
    t_work r_d7;
    t_work r_d8;
    t_work r_d9;
    t_work r_d10;
    logic [50:0] n_w;
    logic [50:0] r_w;
    logic [50:0] w_neg;
    logic n_neg;
    logic r_neg7;
    logic r_neg8;
    logic r_neg9;
    logic r_neg10;
    logic [31:0] n_sm;
    logic [31:0] r_sm7;
    logic [31:0] r_sm8;
    logic [49:0] n_wm;
    logic [49:0] r_wm;
    logic [17:0] r_wm_hi;
    logic [63:0] n_plo;
    logic [63:0] r_plo8;
    logic [63:0] r_plo9;
    logic [49:0] n_phi;
    logic [49:0] r_phi;
    logic [65:0] n_mag;
    logic [32:0] r_mag;
    logic r_big;
    logic [31:0] base;
    logic [34:0] pos_sum;
    logic [31:0] n_pos;
    logic [31:0] r_pos;
    logic r_act;

    // stall chain, from the output back
    always_comb begin
        en[NSTG] = i_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_position = r_pos;
    assign o_active = r_act;

    // stage 6: signed scaled time, Q16 ticks
    always_comb begin
        if (i_data.kind == KIND_LINEAR) begin
            n_w = {3'd0, i_data.dlt, 16'd0};
        end else if (i_data.quarter[1]) begin
            n_w = {2'd0, i_data.tt, 16'd0} + {4'd0, i_data.sterm};
        end else begin
            n_w = {2'd0, i_data.tt, 16'd0} - {4'd0, i_data.sterm};
        end
    end

    // stage 7: sign and magnitudes
    always_comb begin
        w_neg = -r_w;
        n_neg = i_cfg.speed[31] ^ r_w[50];
        n_sm = i_cfg.speed[31] ? (-i_cfg.speed) : i_cfg.speed;
        n_wm = r_w[50] ? w_neg[49:0] : r_w[49:0];
    end

    // stages 8 to 10: partial products, then combine and drop 16 fraction bits
    assign n_plo = 64'(r_sm7) * 64'(r_wm[31:0]);
    assign n_phi = 50'(r_sm8) * 50'(r_wm_hi);
    assign n_mag = {r_phi, 16'd0} + 66'(r_plo9[63:16]);

    // stage 11: add to the base position and saturate
    always_comb begin
        base = (r_d10.kind == KIND_LINEAR) ? i_cfg.speedup_pos : i_cfg.start_pos;
        if (r_neg10) begin
            pos_sum = {{3{base[31]}}, base} - {2'd0, r_mag};
        end else begin
            pos_sum = {{3{base[31]}}, base} + {2'd0, r_mag};
        end
        unique case (r_d10.kind)
            KIND_LINEAR, KIND_SMOOTH: begin
                if (r_big) begin
                    n_pos = r_neg10 ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_pos = sat_q16(pos_sum);
                end
            end
            default: n_pos = r_d10.fixed_pos;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d6 <= i_data;
            r_w <= n_w;
        end
        if (en[1]) begin
            r_d7 <= r_d6;
            r_neg7 <= n_neg;
            r_sm7 <= n_sm;
            r_wm <= n_wm;
        end
        if (en[2]) begin
            r_d8 <= r_d7;
            r_neg8 <= r_neg7;
            r_sm8 <= r_sm7;
            r_wm_hi <= r_wm[49:32];
            r_plo8 <= n_plo;
        end
        if (en[3]) begin
            r_d9 <= r_d8;
            r_neg9 <= r_neg8;
            r_phi <= n_phi;
            r_plo9 <= r_plo8;
        end
        if (en[4]) begin
            r_d10 <= r_d9;
            r_neg10 <= r_neg9;
            r_mag <= n_mag[32:0];
            r_big <= |n_mag[65:33];
        end
        if (en[5]) begin
            r_pos <= n_pos;
            r_act <= r_d10.active;
        end
    end

endmodule
